>>> hdl/pnv_pkg.sv
// Package: shared types, character codes and per-byte helper functions for the path validator.
package pnv_pkg;

  localparam int unsigned MaxPathLenDef = 256;

  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChQuest  = 8'h3F;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChPipe   = 8'h7C;

  localparam logic [2:0] BaseLenMax = 3'd5;

  localparam logic [31:0] Reserved3 [4] = '{
    32'h004E4F43, // CON
    32'h00585541, // AUX
    32'h004E5250, // PRN
    32'h004C554E  // NUL
  };

  localparam logic [31:0] Reserved4 [7] = '{
    32'h314D4F43, 32'h324D4F43, 32'h334D4F43, 32'h344D4F43, // COM1..COM4
    32'h3154504C, 32'h3254504C, 32'h3354504C                // LPT1..LPT3
  };

  typedef struct packed {
    logic        colon_seen;
    logic        text_after_colon;
    logic        already_bad;
    logic        in_segment;
    logic        prev_was_dot;
    logic        base_ended;
    logic [2:0]  base_length;
    logic [31:0] base_prefix;
  } seg_state_t;

  function automatic logic is_forbidden(input logic [7:0] b);
    return ((b >= 8'd1) && (b <= 8'd31)) || (b == ChQuest) || (b == ChQuote) ||
           (b == ChLt) || (b == ChGt) || (b == ChStar) || (b == ChPipe) ||
           (b == ChColon);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) ? (b - 8'd32) : b;
  endfunction

  function automatic logic is_reserved(input logic [2:0] len, input logic [31:0] prefix);
    logic hit;
    hit = 1'b0;
    if (len == 3'd3) begin
      for (int i = 0; i < 4; i++) begin
        if (prefix == Reserved3[i]) hit = 1'b1;
      end
    end else if (len == 3'd4) begin
      for (int i = 0; i < 7; i++) begin
        if (prefix == Reserved4[i]) hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

>>> hdl/pnv_step.sv
// Per-byte next-state and verdict logic of the path validator.
module pnv_step import pnv_pkg::*; #(
  parameter int unsigned MAX_PATH_LEN = MaxPathLenDef,
  localparam int unsigned CntW = $clog2(MAX_PATH_LEN + 1)
) (
  input  seg_state_t     st_i,
  input  logic [CntW-1:0] cnt_i,
  input  logic [7:0]     path_byte_i,
  input  logic           final_byte_i,
  output seg_state_t     st_o,
  output logic [CntW-1:0] cnt_o,
  output logic           path_ok_o
);

  localparam logic [CntW-1:0] CntMax = CntW'(MAX_PATH_LEN);

  seg_state_t      s;
  logic [CntW-1:0] cnt;
  logic            is_sep;
  logic            is_dot;
  logic [7:0]      up;

  assign is_sep = (path_byte_i == ChSlash) || (path_byte_i == ChBslash);
  assign is_dot = (path_byte_i == ChDot);
  assign up     = to_upper(path_byte_i);

  always_comb begin
    s   = st_i;
    cnt = (cnt_i < CntMax) ? (cnt_i + CntW'(1)) : cnt_i;

    if (!s.colon_seen) begin
      if (path_byte_i == ChColon) s.colon_seen = 1'b1;
    end else begin
      s.text_after_colon = 1'b1;
      if (is_sep) begin
        if (s.in_segment) begin
          if (s.prev_was_dot || is_reserved(s.base_length, s.base_prefix)) begin
            s.already_bad = 1'b1;
          end
          s.in_segment = 1'b0;
        end
      end else begin
        if (!s.in_segment) begin
          s.in_segment  = 1'b1;
          s.base_ended  = 1'b0;
          s.base_length = 3'd0;
          s.base_prefix = '0;
        end
        if (is_forbidden(path_byte_i)) s.already_bad = 1'b1;
        s.prev_was_dot = is_dot;
        if (!s.base_ended) begin
          if (is_dot) begin
            s.base_ended = 1'b1;
          end else begin
            case (s.base_length)
              3'd0: s.base_prefix[7:0]   = up;
              3'd1: s.base_prefix[15:8]  = up;
              3'd2: s.base_prefix[23:16] = up;
              3'd3: s.base_prefix[31:24] = up;
              default: ;
            endcase
            if (s.base_length < BaseLenMax) s.base_length = s.base_length + 3'd1;
          end
        end
      end
    end

    if (s.in_segment && (s.prev_was_dot || is_reserved(s.base_length, s.base_prefix))) begin
      path_ok_o = 1'b0;
    end else begin
      path_ok_o = !s.already_bad && s.colon_seen && s.text_after_colon && (cnt < CntMax);
    end

    if (final_byte_i) begin
      st_o  = '0;
      cnt_o = '0;
    end else begin
      st_o  = s;
      cnt_o = cnt;
    end
  end

endmodule

>>> hdl/path_name_validator_core.sv
// Top level: input register, per-byte path checker and verdict output register.
// A final byte's verdict goes from the input register into the verdict register on path_ok_o.
// Throughput: one byte per cycle, back to back; each register holds one beat.
// The input register stalls only when it holds a final byte while the verdict waits.
// Reset (rst_ni low, asynchronous): all path state clears, both valid flags drop.
// No clearing pass; in_ready_o is high as soon as reset is released.
module path_name_validator_core import pnv_pkg::*; #(
  parameter int unsigned MAX_PATH_LEN = MaxPathLenDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] path_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       path_ok_o
);

  localparam int unsigned CntW = $clog2(MAX_PATH_LEN + 1);

  logic            in_vld_q;
  logic [7:0]      byte_q;
  logic            final_q;
  seg_state_t      st_q, st_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ok_d, ok_q;
  logic            out_vld_q;
  logic            advance;
  logic            in_acc;

  assign advance    = !(in_vld_q && final_q && out_vld_q && !out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign in_acc     = in_valid_i && in_ready_o;

  pnv_step #(
    .MAX_PATH_LEN(MAX_PATH_LEN)
  ) u_step (
    .st_i        (st_q),
    .cnt_i       (cnt_q),
    .path_byte_i (byte_q),
    .final_byte_i(final_q),
    .st_o        (st_d),
    .cnt_o       (cnt_d),
    .path_ok_o   (ok_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '0;
      cnt_q     <= '0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (in_vld_q && advance) begin
        st_q  <= st_d;
        cnt_q <= cnt_d;
      end
      if (in_vld_q && final_q && advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q  <= path_byte_i;
      final_q <= final_byte_i;
    end
    if (in_vld_q && final_q && advance) ok_q <= ok_d;
  end

  assign out_valid_o = out_vld_q;
  assign path_ok_o   = ok_q;

endmodule

>>> hdl/pnv_checker.sv
// Port-level checker for the path validator and its bind to the top level.
module pnv_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] path_byte_i,
  input logic       final_byte_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       path_ok_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(path_ok_o))
    else $error("verdict dropped or changed while stalled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a stalled verdict");

  a_free_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input not ready while verdict register empty");

  a_rise_from_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_ready_o))
    else $error("verdict appeared while input side stalled");

endmodule

bind path_name_validator_core pnv_checker u_pnv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .path_byte_i (path_byte_i),
  .final_byte_i(final_byte_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .path_ok_o   (path_ok_o)
);

>>> test/path_name_validator_core_tb.sv
// Testbench for path_name_validator_core: directed path table, then random paths vs a predictor.
`timescale 1ns / 1ps

module path_name_validator_core_tb import pnv_pkg::*; ();

  localparam int PathLimit = MaxPathLenDef;
  localparam int NumDevNames = 16;
  localparam int NumReserved = 11;
  localparam int NumRows = 26;
  localparam int PhaseBeats = 390;
  localparam int HoldCycles = 300;
  localparam int StallLimit = 5000;

  typedef enum logic [1:0] {
    VERDICT_MODEL,
    VERDICT_OK,
    VERDICT_BAD
  } verdict_src_e;

  typedef struct {
    string        text;
    int           pad;
    verdict_src_e src;
  } path_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] path_byte_i;
  logic       final_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       path_ok_o;

  path_row_t dir_rows [NumRows] = '{
    '{"C:\\a", 0, VERDICT_OK},
    '{"abc", 0, VERDICT_BAD},
    '{"x", 0, VERDICT_BAD},
    '{"C:", 0, VERDICT_BAD},
    '{":", 0, VERDICT_BAD},
    '{":x", 0, VERDICT_OK},
    '{"?*<>|\001:ok", 0, VERDICT_MODEL},
    '{"C:\\CON", 0, VERDICT_BAD},
    '{"C:\\con.txt", 0, VERDICT_BAD},
    '{"d:/x/aux", 0, VERDICT_BAD},
    '{"C:\\Prn.", 0, VERDICT_BAD},
    '{"C:\\a\\nUl\\b", 0, VERDICT_BAD},
    '{"C:\\com1", 0, VERDICT_BAD},
    '{"C:\\COM4.log", 0, VERDICT_BAD},
    '{"C:\\lpt3", 0, VERDICT_BAD},
    '{"C:\\LPT4\\COM5\\CONX\\CO", 0, VERDICT_MODEL},
    '{"C:\\dir.", 0, VERDICT_BAD},
    '{"C:.\\x", 0, VERDICT_BAD},
    '{"C:\\a?b", 0, VERDICT_BAD},
    '{"C:\"<>*|", 0, VERDICT_BAD},
    '{"C:x:y", 0, VERDICT_BAD},
    '{"C:a\037b", 0, VERDICT_BAD},
    '{"C:\\\177\200\377.a", 0, VERDICT_MODEL},
    '{"C:\\\\//", 0, VERDICT_MODEL},
    '{"C:\\", PathLimit - 4, VERDICT_OK},
    '{"C:\\", PathLimit - 3, VERDICT_BAD}
  };

  string dev_names [NumDevNames] = '{
    "CON", "AUX", "PRN", "NUL", "COM1", "COM2", "COM3", "COM4", "LPT1", "LPT2", "LPT3",
    "COM5", "LPT4", "CONX", "NU", "COM0"
  };
  string forbid_chars = "?\"<>*|:";

  // predictor state
  int          path_len;
  bit          colon_seen;
  bit          after_colon;
  bit          seg_bad;
  bit          in_seg;
  bit          prev_dot;
  bit          base_done;
  logic [2:0]  base_len;
  logic [31:0] base_pfx;

  bit          verdict_q [$];
  logic [7:0]  path_buf [$];
  int          errors;
  int          beats_sent;
  int          snd_idle_pct;
  int          rcv_idle_pct;
  bit          hold_req;
  int          hold_left;
  int          stall_cnt;
  bit          want_ok;

  path_name_validator_core #(
    .MAX_PATH_LEN(PathLimit)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .path_byte_i (path_byte_i),
    .final_byte_i(final_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .path_ok_o   (path_ok_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic bit banned_byte(input logic [7:0] b);
    bit hit;
    hit = (b >= 8'd1) && (b <= 8'd31);
    for (int i = 0; i < forbid_chars.len(); i++) begin
      if (b == forbid_chars[i]) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic bit device_base(input logic [2:0] len, input logic [31:0] pfx);
    bit hit;
    bit same;
    hit = 1'b0;
    for (int n = 0; n < NumReserved; n++) begin
      if (dev_names[n].len() == int'(len)) begin
        same = 1'b1;
        for (int i = 0; i < int'(len); i++) begin
          if (pfx[8*i +: 8] != dev_names[n][i]) same = 1'b0;
        end
        if (same) hit = 1'b1;
      end
    end
    return hit;
  endfunction

  task automatic clear_path_state();
    path_len = 0;
    colon_seen = 1'b0;
    after_colon = 1'b0;
    seg_bad = 1'b0;
    in_seg = 1'b0;
    prev_dot = 1'b0;
    base_done = 1'b0;
    base_len = '0;
    base_pfx = '0;
  endtask

  task automatic end_segment();
    if (prev_dot) seg_bad = 1'b1;
    if (device_base(base_len, base_pfx)) seg_bad = 1'b1;
    in_seg = 1'b0;
  endtask

  task automatic track_path_byte(input logic [7:0] b, input bit last, output bit done,
                                 output bit ok);
    logic [7:0] up;
    if (path_len < PathLimit) path_len++;
    if (!colon_seen) begin
      if (b == ChColon) colon_seen = 1'b1;
    end else begin
      after_colon = 1'b1;
      if (b == ChSlash || b == ChBslash) begin
        if (in_seg) end_segment();
      end else begin
        if (!in_seg) begin
          in_seg = 1'b1;
          prev_dot = 1'b0;
          base_done = 1'b0;
          base_len = '0;
          base_pfx = '0;
        end
        if (banned_byte(b)) seg_bad = 1'b1;
        prev_dot = (b == ChDot);
        if (!base_done) begin
          if (b == ChDot) begin
            base_done = 1'b1;
          end else begin
            up = (b >= "a" && b <= "z") ? b - 8'd32 : b;
            if (base_len < 3'd4) base_pfx[8*int'(base_len) +: 8] = up;
            if (base_len < BaseLenMax) base_len = base_len + 3'd1;
          end
        end
      end
    end
    done = last;
    ok = 1'b0;
    if (last) begin
      if (in_seg) end_segment();
      ok = !seg_bad && colon_seen && after_colon && (path_len < PathLimit);
      clear_path_state();
    end
  endtask

  function automatic logic [7:0] plain_char();
    int r;
    logic [7:0] c;
    r = $urandom_range(0, 19);
    if (r < 12) begin
      c = 8'("A" + $urandom_range(0, 25));
      if ($urandom_range(0, 1)) c = c + 8'd32;
    end else if (r < 15) begin
      c = 8'("0" + $urandom_range(0, 9));
    end else if (r < 17) begin
      c = 8'($urandom_range(128, 255));
    end else if (r == 17) begin
      c = ChDot;
    end else if (r == 18) begin
      c = " ";
    end else begin
      c = "-";
    end
    return c;
  endfunction

  function automatic logic [7:0] banned_char();
    if ($urandom_range(0, 13) < 7) return forbid_chars[$urandom_range(0, 6)];
    return 8'($urandom_range(1, 31));
  endfunction

  task automatic add_segment();
    int k;
    int len;
    string nm;
    logic [7:0] c;
    k = $urandom_range(0, 9);
    if (k <= 2) begin
      nm = dev_names[$urandom_range(0, NumDevNames - 1)];
      for (int i = 0; i < nm.len(); i++) begin
        c = nm[i];
        if (c >= "A" && c <= "Z" && $urandom_range(0, 1)) c = c + 8'd32;
        path_buf.push_back(c);
      end
      if ($urandom_range(0, 2) == 0) begin
        path_buf.push_back(ChDot);
        repeat ($urandom_range(0, 3)) path_buf.push_back(plain_char());
      end
    end else if (k <= 8) begin
      len = $urandom_range(1, 8);
      repeat (len) path_buf.push_back(plain_char());
      if (k == 7) path_buf[$urandom_range(path_buf.size() - len, path_buf.size() - 1)] =
          banned_char();
      if (k == 8) path_buf.push_back(ChDot);
    end
  endtask

  task automatic build_random_path();
    int r;
    int len;
    int target;
    path_buf.delete();
    r = $urandom_range(0, 59);
    if (r < 6) begin
      len = $urandom_range(1, 12);
      repeat (len) path_buf.push_back(8'($urandom_range(1, 255)));
      if ($urandom_range(0, 1)) path_buf[$urandom_range(0, len - 1)] = ChColon;
      return;
    end
    repeat ($urandom_range(0, 3)) path_buf.push_back(8'($urandom_range(1, 255)));
    path_buf.push_back(ChColon);
    for (int s = 0; s < $urandom_range(0, 4); s++) begin
      if (s > 0 || $urandom_range(0, 3) != 0)
        path_buf.push_back($urandom_range(0, 1) ? ChSlash : ChBslash);
      add_segment();
    end
    if ($urandom_range(0, 7) == 0) path_buf.push_back($urandom_range(0, 1) ? ChSlash : ChBslash);
    if (r == 6) begin
      target = $urandom_range(PathLimit - 6, PathLimit + 4);
      path_buf.push_back(ChBslash);
      while (path_buf.size() < target) path_buf.push_back(8'("a" + $urandom_range(0, 25)));
    end
  endtask

  task automatic send_path(input verdict_src_e src);
    bit done;
    bit ok;
    int n;
    n = path_buf.size();
    for (int i = 0; i < n; i++) begin
      while ($urandom_range(0, 99) < snd_idle_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i   <= 1'b1;
      path_byte_i  <= path_buf[i];
      final_byte_i <= (i == n - 1);
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      track_path_byte(path_buf[i], i == n - 1, done, ok);
      if (done) verdict_q.push_back(src == VERDICT_MODEL ? ok : (src == VERDICT_OK));
      beats_sent++;
    end
  endtask

  task automatic drain_verdicts();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected verdict beat, expected none, got path_ok=%0b", $time,
                 path_ok_o);
        errors++;
      end else begin
        want_ok = verdict_q.pop_front();
        if (path_ok_o !== want_ok) begin
          $display("%0t: path_ok mismatch, expected %0b, got %0b", $time, want_ok, path_ok_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("%0t: no beat accepted for %0d cycles", $time, stall_cnt);
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    int start;
    bit hold_done;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    path_byte_i = '0;
    final_byte_i = 1'b0;
    hold_req = 1'b0;
    errors = 0;
    beats_sent = 0;
    stall_cnt = 0;
    hold_done = 1'b0;
    snd_idle_pct = 21;
    rcv_idle_pct = 85;
    clear_path_state();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      path_buf.delete();
      for (int i = 0; i < dir_rows[r].text.len(); i++) path_buf.push_back(dir_rows[r].text[i]);
      repeat (dir_rows[r].pad) path_buf.push_back("a");
      send_path(dir_rows[r].src);
    end
    drain_verdicts();

    for (int p = 0; p < 3; p++) begin
      snd_idle_pct = (p == 0) ? 21 : (p == 1) ? 85 : 0;
      rcv_idle_pct = (p == 0) ? 85 : (p == 1) ? 21 : 0;
      start = beats_sent;
      while (beats_sent - start < PhaseBeats) begin
        if (p == 2 && !hold_done && beats_sent - start > 100) begin
          hold_req = 1'b1;
          hold_done = 1'b1;
        end
        build_random_path();
        send_path(VERDICT_MODEL);
      end
      drain_verdicts();
    end

    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/pnv_pkg.sv
hdl/pnv_step.sv
hdl/path_name_validator_core.sv
hdl/pnv_checker.sv
test/path_name_validator_core_tb.sv
